// ===== hdl/sbfr_pkg.sv =====
`default_nettype none

package sbfr_pkg;

  // frame layout
  localparam int FRAME_BYTES   = 25;
  localparam int CHANNELS      = 8;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
  localparam int FLAGS_INDEX   = FRAME_BYTES - 3;
  localparam int CHAN_W        = 11;
  localparam int UNPACK_BYTES  = (CHANNELS * CHAN_W + 7) / 8;
  localparam int UNP_IDX_W     = $clog2(UNPACK_BYTES);
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int EVT_W         = 3;

  // register reset values
  localparam logic [7:0] START_BYTE_RST   = 8'd15;
  localparam logic [7:0] END_BYTE_RST     = 8'd0;
  localparam logic [7:0] LOST_MASK_RST    = 8'd4;
  localparam logic [7:0] FS_MASK_RST      = 8'd8;
  localparam logic [7:0] GAP_TICKS_RST    = 8'd2;
  localparam logic [7:0] LOSS_TICKS_RST   = 8'd64;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE  = 3'd0,
    CFG_END_BYTE    = 3'd1,
    CFG_LOST_MASK   = 3'd2,
    CFG_FS_MASK     = 3'd3,
    CFG_GAP_TICKS   = 3'd4,
    CFG_LOSS_TICKS  = 3'd5
  } cfg_idx_t;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_UPDATED  = 3'd1,
    EV_FAILSAFE = 3'd2,
    EV_LOST     = 3'd3,
    EV_BAD_END  = 3'd4,
    EV_TIMEOUT  = 3'd5
  } evt_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] lost_frame_mask;
    logic [7:0] failsafe_mask;
    logic [7:0] gap_ticks;
    logic [7:0] signal_loss_ticks;
  } cfg_t;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] chans_t;

  typedef struct packed {
    chans_t chans;
    evt_t   evt;
    logic   in_sync;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== hdl/sbfr_in_if.sv =====
`default_nettype none

interface sbfr_in_if;
  import sbfr_pkg::*;

  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbfr_out_if.sv =====
`default_nettype none

interface sbfr_out_if;
  import sbfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;
  logic [CHAN_W-1:0] chan_d;
  logic [CHAN_W-1:0] chan_e;
  logic [CHAN_W-1:0] chan_f;
  logic [CHAN_W-1:0] chan_g;
  logic [CHAN_W-1:0] chan_h;
  logic [EVT_W-1:0]  event_res;
  logic              in_sync;

  modport source (output valid, output chan_a, output chan_b, output chan_c, output chan_d,
                  output chan_e, output chan_f, output chan_g, output chan_h,
                  output event_res, output in_sync, input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c, input chan_d,
                  input chan_e, input chan_f, input chan_g, input chan_h,
                  input event_res, input in_sync, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbfr_cfg_if.sv =====
`default_nettype none

interface sbfr_cfg_if;
  import sbfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [7:0]           wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbus_frame_receiver_unit.sv =====
`default_nettype none

// 25-byte serial frame receiver: each input transfer is a received byte or a
// timer tick, and each one yields exactly one result transfer holding the eight
// current 11-bit channels, an event code and the sync flag. One item is taken
// every cycle; its result appears in the output register on the next cycle.
// While a result waits in the output register the input is held off, unless the
// sink takes that result in the same cycle. The rate is set by the single decode
// step between the state registers and the output register. Configuration
// writes are always accepted and take effect on the following cycle; write them
// only while idle. No start-up clearing pass is needed after reset.
module sbus_frame_receiver_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  sbfr_in_if.sink   in_ch,
  sbfr_out_if.source out_ch,
  sbfr_cfg_if.sink  cfg_ch
);
  import sbfr_pkg::*;

  cfg_t     cfg;
  dec_res_t res;
  dec_res_t res_r;
  logic     out_valid_r;
  logic     acc;

  // input taken when the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  sbfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sbfr_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .operation (in_ch.operation),
    .data_byte (in_ch.data_byte),
    .cfg       (cfg),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.chan_a    = res_r.chans[0];
  assign out_ch.chan_b    = res_r.chans[1];
  assign out_ch.chan_c    = res_r.chans[2];
  assign out_ch.chan_d    = res_r.chans[3];
  assign out_ch.chan_e    = res_r.chans[4];
  assign out_ch.chan_f    = res_r.chans[5];
  assign out_ch.chan_g    = res_r.chans[6];
  assign out_ch.chan_h    = res_r.chans[7];
  assign out_ch.event_res = res_r.evt;
  assign out_ch.in_sync   = res_r.in_sync;

`ifndef SYNTH
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted item produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !acc)
    else $error("pending result overwritten");
  a_idle_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbfr_cfg_regs.sv =====
`default_nettype none

module sbfr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sbfr_cfg_if.sink           cfg_ch,
  output sbfr_pkg::cfg_t     cfg
);
  import sbfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;

  // register decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.reg_idx))
        CFG_START_BYTE: cfg_nxt.start_byte        = cfg_ch.wdata;
        CFG_END_BYTE:   cfg_nxt.end_byte          = cfg_ch.wdata;
        CFG_LOST_MASK:  cfg_nxt.lost_frame_mask   = cfg_ch.wdata;
        CFG_FS_MASK:    cfg_nxt.failsafe_mask     = cfg_ch.wdata;
        CFG_GAP_TICKS:  cfg_nxt.gap_ticks         = cfg_ch.wdata;
        CFG_LOSS_TICKS: cfg_nxt.signal_loss_ticks = cfg_ch.wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte        <= START_BYTE_RST;
      cfg_r.end_byte          <= END_BYTE_RST;
      cfg_r.lost_frame_mask   <= LOST_MASK_RST;
      cfg_r.failsafe_mask     <= FS_MASK_RST;
      cfg_r.gap_ticks         <= GAP_TICKS_RST;
      cfg_r.signal_loss_ticks <= LOSS_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/sbfr_decoder.sv =====
`default_nettype none

module sbfr_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic          operation,
  input  wire logic [7:0]    data_byte,
  input  sbfr_pkg::cfg_t     cfg,
  output sbfr_pkg::dec_res_t res
);
  import sbfr_pkg::*;

  logic                 coll_r, coll_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [7:0]           gap_r, gap_nxt;
  logic [7:0]           loss_r, loss_nxt;
  chans_t               chan_r, chan_nxt;
  logic [7:0]           flags_r, flags_nxt;
  logic [7:0]           data_r [UNPACK_BYTES];
  logic                 data_we;
  logic [UNPACK_BYTES*8-1:0] flat;
  chans_t               unpacked;
  evt_t                 evt;

  // channel unpack: little-endian 11-bit fields over the first payload bytes
  always_comb begin
    for (int i = 0; i < UNPACK_BYTES; i++) begin
      flat[8*i +: 8] = data_r[i];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      unpacked[c] = flat[CHAN_W*c +: CHAN_W];
    end
  end

  // byte and tick handling
  always_comb begin
    coll_nxt  = coll_r;
    cnt_nxt   = cnt_r;
    gap_nxt   = gap_r;
    loss_nxt  = loss_r;
    chan_nxt  = chan_r;
    flags_nxt = flags_r;
    data_we   = 1'b0;
    evt       = EV_NONE;
    if (op_t'(operation) == OP_TICK) begin
      if (gap_r >= cfg.gap_ticks) begin
        gap_nxt  = '0;
        coll_nxt = 1'b0;
      end else begin
        gap_nxt = gap_r + 8'd1;
      end
      if (loss_r >= cfg.signal_loss_ticks) begin
        chan_nxt = '0;
        loss_nxt = '0;
        evt      = EV_TIMEOUT;
      end else begin
        loss_nxt = loss_r + 8'd1;
      end
    end else begin
      gap_nxt = '0;
      if (!coll_r) begin
        if (data_byte == cfg.start_byte) begin
          cnt_nxt  = '0;
          coll_nxt = 1'b1;
        end
      end else if (cnt_r < CNT_W'(PAYLOAD_BYTES)) begin
        data_we = (cnt_r < CNT_W'(UNPACK_BYTES));
        if (cnt_r == CNT_W'(FLAGS_INDEX)) begin
          flags_nxt = data_byte;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        coll_nxt = 1'b0;
        if (data_byte == cfg.end_byte) begin
          if ((flags_r & cfg.lost_frame_mask) != 8'd0) begin
            evt = EV_LOST;
          end else if ((flags_r & cfg.failsafe_mask) != 8'd0) begin
            chan_nxt = '0;
            evt      = EV_FAILSAFE;
          end else begin
            chan_nxt = unpacked;
            loss_nxt = '0;
            evt      = EV_UPDATED;
          end
        end else begin
          evt = EV_BAD_END;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= 1'b0;
      cnt_r  <= '0;
      gap_r  <= '0;
      loss_r <= '0;
      chan_r <= '0;
    end else if (acc) begin
      coll_r <= coll_nxt;
      cnt_r  <= cnt_nxt;
      gap_r  <= gap_nxt;
      loss_r <= loss_nxt;
      chan_r <= chan_nxt;
    end
  end

  // payload bytes, written before they are read
  always_ff @(posedge clk) begin
    if (acc) begin
      flags_r <= flags_nxt;
      if (data_we) begin
        data_r[cnt_r[UNP_IDX_W-1:0]] <= data_byte;
      end
    end
  end

  // result for this transfer
  assign res.chans   = chan_nxt;
  assign res.evt     = evt;
  assign res.in_sync = coll_nxt;

`ifndef SYNTH
  a_update_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.evt == EV_UPDATED |=> !coll_r && loss_r == 8'd0)
    else $error("frame update did not end collection");
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.evt == EV_TIMEOUT |=> chan_r == '0 && loss_r == 8'd0)
    else $error("loss timeout did not clear channels");
  a_byte_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op_t'(operation) == OP_BYTE |=> gap_r == 8'd0)
    else $error("byte did not clear gap timer");
  a_gap_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
    acc && op_t'(operation) == OP_TICK && gap_r >= cfg.gap_ticks |=> !coll_r)
    else $error("gap timeout did not drop sync");
`endif

endmodule

`default_nettype wire

// ===== bench/sbfr_checker.sv =====
`default_nettype none

module sbfr_checker (
  input  logic        clk,
  input  logic        rst_n,
  sbfr_in_if          in_mon,
  sbfr_out_if         out_mon,
  sbfr_cfg_if         cfg_mon,
  output int unsigned mismatch_total,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbfr_pkg::*;

  // shadow copy of the receiver registers and state
  cfg_t             cfg_now;
  logic             sync_now;
  logic [CNT_W-1:0] byte_idx;
  logic [7:0]       payload_seen [PAYLOAD_BYTES];
  chans_t           chan_state;
  logic [7:0]       gap_count;
  logic [7:0]       loss_count;

  // results still owed by the block, oldest first
  dec_res_t results_due [$];

  task automatic flag_failure(input string what);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  task automatic compare_field(input string field, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      flag_failure($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    end
  endtask

  // one received byte: framing, flags check and channel unpacking
  task automatic advance_on_byte(input logic [7:0] rx, output evt_t ev);
    logic [UNPACK_BYTES*8-1:0] bitstream;
    logic [7:0]                flags;
    ev = EV_NONE;
    if (!sync_now) begin
      if (rx == cfg_now.start_byte) begin
        byte_idx = '0;
        sync_now = 1'b1;
      end
    end else if (byte_idx < PAYLOAD_BYTES) begin
      payload_seen[byte_idx] = rx;
      byte_idx = byte_idx + 1'b1;
    end else begin
      if (rx == cfg_now.end_byte) begin
        flags = payload_seen[FLAGS_INDEX];
        if ((flags & cfg_now.lost_frame_mask) != 8'h00) begin
          ev = EV_LOST;
        end else if ((flags & cfg_now.failsafe_mask) != 8'h00) begin
          chan_state = '0;
          ev = EV_FAILSAFE;
        end else begin
          // channels are packed lsb first across the leading payload bytes
          for (int k = 0; k < UNPACK_BYTES; k++) begin
            bitstream[k*8 +: 8] = payload_seen[k];
          end
          for (int c = 0; c < CHANNELS; c++) begin
            chan_state[c] = bitstream[c*CHAN_W +: CHAN_W];
          end
          loss_count = '0;
          ev = EV_UPDATED;
        end
      end else begin
        ev = EV_BAD_END;
      end
      sync_now = 1'b0;
    end
    gap_count = '0;
  endtask

  // one timer tick: gap and loss timers with a carry bit on the compare
  task automatic advance_on_tick(output evt_t ev);
    logic [8:0] gap_next;
    logic [8:0] loss_next;
    ev = EV_NONE;
    gap_next  = {1'b0, gap_count} + 9'd1;
    loss_next = {1'b0, loss_count} + 9'd1;
    if (gap_next > {1'b0, cfg_now.gap_ticks}) begin
      gap_count = '0;
      sync_now  = 1'b0;
    end else begin
      gap_count = gap_next[7:0];
    end
    if (loss_next > {1'b0, cfg_now.signal_loss_ticks}) begin
      chan_state = '0;
      loss_count = '0;
      ev = EV_TIMEOUT;
    end else begin
      loss_count = loss_next[7:0];
    end
  endtask

  always @(posedge clk) begin
    dec_res_t fresh;
    dec_res_t oldest;
    chans_t   seen_chans;
    evt_t     ev;
    if (!rst_n) begin
      cfg_now = '{START_BYTE_RST, END_BYTE_RST, LOST_MASK_RST, FS_MASK_RST,
                  GAP_TICKS_RST, LOSS_TICKS_RST};
      sync_now = 1'b0;
      byte_idx = '0;
      chan_state = '0;
      gap_count = '0;
      loss_count = '0;
      results_due.delete();
      mismatch_total = 0;
    end else begin
      // register writes; indexes past the list are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_idx)
          CFG_START_BYTE: cfg_now.start_byte = cfg_mon.wdata;
          CFG_END_BYTE:   cfg_now.end_byte = cfg_mon.wdata;
          CFG_LOST_MASK:  cfg_now.lost_frame_mask = cfg_mon.wdata;
          CFG_FS_MASK:    cfg_now.failsafe_mask = cfg_mon.wdata;
          CFG_GAP_TICKS:  cfg_now.gap_ticks = cfg_mon.wdata;
          CFG_LOSS_TICKS: cfg_now.signal_loss_ticks = cfg_mon.wdata;
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          flag_failure("result transfer with no result pending");
        end else begin
          oldest = results_due.pop_front();
          seen_chans = {out_mon.chan_h, out_mon.chan_g, out_mon.chan_f, out_mon.chan_e,
                        out_mon.chan_d, out_mon.chan_c, out_mon.chan_b, out_mon.chan_a};
          for (int c = 0; c < CHANNELS; c++) begin
            compare_field($sformatf("channel %0d", c + 1), oldest.chans[c], seen_chans[c]);
          end
          compare_field("event", oldest.evt, out_mon.event_res);
          compare_field("in_sync", oldest.in_sync, out_mon.in_sync);
        end
      end

      // input transfer: run the decoder one step
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_TICK) begin
          advance_on_tick(ev);
        end else begin
          advance_on_byte(in_mon.data_byte, ev);
        end
        fresh.chans = chan_state;
        fresh.evt = ev;
        fresh.in_sync = sync_now;
        results_due.push_back(fresh);
      end
    end
    results_owed = results_due.size();
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          PHASE_ITEMS   = 40;

  // indexes past the register list, written to show they are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic        clk;
  logic        rst_n;
  int          idle_pct;
  int          stall_pct;
  cfg_t        cur_cfg;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  int unsigned mismatch_total;
  int unsigned results_owed;

  sbfr_in_if  in_ch ();
  sbfr_out_if out_ch ();
  sbfr_cfg_if cfg_ch ();

  sbus_frame_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sbfr_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input op_t op, input logic [7:0] rx);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= rx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // hold the input until the block has delivered every result
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // write the whole register set, optionally followed by out-of-range indexes
  task automatic apply_setup(input cfg_t c, input bit with_spare);
    put_reg(CFG_START_BYTE, c.start_byte);
    put_reg(CFG_END_BYTE, c.end_byte);
    put_reg(CFG_LOST_MASK, c.lost_frame_mask);
    put_reg(CFG_FS_MASK, c.failsafe_mask);
    put_reg(CFG_GAP_TICKS, c.gap_ticks);
    put_reg(CFG_LOSS_TICKS, c.signal_loss_ticks);
    if (with_spare) begin
      put_reg(CFG_SPARE_A, 8'($urandom_range(255)));
      put_reg(CFG_SPARE_B, 8'($urandom_range(255)));
    end
    cfg_ch.valid <= 1'b0;
    cur_cfg = c;
  endtask

  // a whole frame with random payload, flags aimed at the masks,
  // an occasional tick between bytes and now and then a wrong end byte
  task automatic send_frame();
    logic [7:0] flags;
    logic [7:0] both_masks;
    int         fill;
    both_masks = cur_cfg.lost_frame_mask | cur_cfg.failsafe_mask;
    case ($urandom_range(5))
      0: flags = 8'($urandom_range(255));
      1: flags = cur_cfg.lost_frame_mask | 8'($urandom_range(255));
      2: flags = (cur_cfg.failsafe_mask | 8'($urandom_range(255)))
                 & ~cur_cfg.lost_frame_mask;
      3: flags = both_masks;
      default: flags = 8'($urandom_range(255)) & ~both_masks;
    endcase
    fill = $urandom_range(9);
    send_item(OP_BYTE, cur_cfg.start_byte);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if ($urandom_range(9) == 0) begin
        send_ticks($urandom_range(1, 3));
      end
      if (k == FLAGS_INDEX) begin
        send_item(OP_BYTE, flags);
      end else if (fill == 0) begin
        send_item(OP_BYTE, 8'h00);
      end else if (fill == 1) begin
        send_item(OP_BYTE, 8'hFF);
      end else begin
        send_item(OP_BYTE, 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 85) begin
      send_item(OP_BYTE, cur_cfg.end_byte);
    end else begin
      send_item(OP_BYTE, 8'($urandom_range(255)));
    end
  endtask

  // mostly frames, some tick bursts, line noise and pauses to drain, then a tick run
  // long enough for the loss timer to expire
  task automatic run_traffic(input int quota);
    int unsigned first;
    int          pick;
    first = items_sent;
    while (items_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame();
      end else if (pick < 75) begin
        send_ticks($urandom_range(1, 6));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 5)) send_item(OP_BYTE, 8'($urandom_range(255)));
      end else begin
        settle();
      end
    end
    send_ticks(int'(cur_cfg.signal_loss_ticks) + 1);
  endtask

  initial begin
    cfg_t phase_cfg [6];
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_BYTE;
    in_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_idx = CFG_START_BYTE;
    cfg_ch.wdata = 8'h00;

    // start, end, lost mask, failsafe mask, gap ticks, loss ticks
    phase_cfg[0] = '{8'h0F, 8'h00, 8'h04, 8'h08, 8'd2, 8'd64};
    phase_cfg[1] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'd1, 8'd1};
    phase_cfg[2] = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'd255, 8'd255};
    phase_cfg[3] = '{8'hA5, 8'h5A, 8'h80, 8'h01, 8'd3, 8'd10};
    phase_cfg[4] = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'(1 << $urandom_range(7)), 8'(1 << $urandom_range(7)),
                     8'($urandom_range(1, 8)), 8'($urandom_range(1, 40))};
    phase_cfg[5] = '{8'h0F, 8'h00, 8'h04, 8'h08, 8'd2, 8'd64};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored byte, full-scale frame, loss timeout
    apply_setup('{8'h0F, 8'h00, 8'h04, 8'h08, 8'd2, 8'd2}, 1'b0);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, cur_cfg.start_byte);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      send_item(OP_BYTE, (k == FLAGS_INDEX) ? 8'h00 : 8'hFF);
    end
    send_item(OP_BYTE, cur_cfg.end_byte);
    send_ticks(3);

    // random phases, each applying a register set from the table and an idle pattern
    for (int p = 0; p < 6; p++) begin
      settle();
      idle_pct  = (p < 2) ? 33 : (p < 4) ? 62 : 0;
      stall_pct = (p < 2) ? 62 : (p < 4) ? 33 : 0;
      apply_setup(phase_cfg[p], p == 5);
      run_traffic(PHASE_ITEMS);
    end

    settle();
    @(negedge clk);
    if (mismatch_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
